// ===== design/mts_pkg.sv =====
package mts_pkg;

  // field widths of the stream words
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned REG_W    = 4;

  // padded tdata widths, whole bytes, and tuser widths
  localparam int unsigned S_TDATA_W = 64;
  localparam int unsigned S_TUSER_W = 3;
  localparam int unsigned M_TDATA_W = 40;
  localparam int unsigned M_TUSER_W = 2;

  // defaults for top-level parameters
  localparam int unsigned TAR_WRAP_BYTES_DEF = 1024;
  localparam int unsigned QUEUE_DEPTH_DEF    = 2;

  // request kinds
  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE8      = 3'd0,
    ACT_WRITE16     = 3'd1,
    ACT_WRITE32     = 3'd2,
    ACT_READ32      = 3'd3,
    ACT_BURST_START = 3'd4,
    ACT_BURST_WRITE = 3'd5,
    ACT_BURST_READ  = 3'd6,
    ACT_BURST_END   = 3'd7
  } action_e;

  // debug-port and access-port register byte addresses
  localparam logic [REG_W-1:0] REG_SELECT = 4'h8;
  localparam logic [REG_W-1:0] REG_RDBUFF = 4'hC;
  localparam logic [REG_W-1:0] REG_CSW    = 4'h0;
  localparam logic [REG_W-1:0] REG_TAR    = 4'h4;
  localparam logic [REG_W-1:0] REG_DRW    = 4'hC;

  // csw values
  localparam logic [DATA_W-1:0] CSW_BASE    = 32'hA200_0000;
  localparam logic [DATA_W-1:0] CSW_AUTOINC = 32'h0000_0010;
  localparam logic [DATA_W-1:0] CSW_SIZE8   = 32'h0000_0000;
  localparam logic [DATA_W-1:0] CSW_SIZE16  = 32'h0000_0001;
  localparam logic [DATA_W-1:0] CSW_SIZE32  = 32'h0000_0002;
  localparam logic [DATA_W-1:0] SHADOW_RST  = 32'hFFFF_FFFF;

  // select write keeps the low nibble of the all-ones shadow, ap and bank zero
  localparam logic [DATA_W-1:0] SELECT_VALUE = 32'h0000_000F;

  // transaction slots of one request, in issue order
  localparam int unsigned NUM_SLOTS   = 6;
  localparam int unsigned SLOT_SEL    = 0;
  localparam int unsigned SLOT_CSW    = 1;
  localparam int unsigned SLOT_TARPRE = 2;
  localparam int unsigned SLOT_DRW    = 3;
  localparam int unsigned SLOT_TARPST = 4;
  localparam int unsigned SLOT_RDBUF  = 5;

  // one classified request
  typedef struct packed {
    logic [NUM_SLOTS-1:0] slots;
    logic [DATA_W-1:0]    csw;
    logic [ADDR_W-1:0]    tar;
    logic                 drw_write;
    logic [DATA_W-1:0]    drw_data;
  } cmd_t;

  // one register transaction
  typedef struct packed {
    logic              last;
    logic [DATA_W-1:0] wdata;
    logic [REG_W-1:0]  reg_addr;
    logic              is_write;
    logic              ap_not_dp;
  } xact_t;

endpackage

// ===== design/mts_front.sv =====
module mts_front #(
  parameter int unsigned TAR_WRAP_BYTES = mts_pkg::TAR_WRAP_BYTES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               req_valid_i,
  output logic                               req_ready_o,
  input  logic [mts_pkg::ACTION_W-1:0]       action_i,
  input  logic [mts_pkg::ADDR_W-1:0]         address_i,
  input  logic [mts_pkg::DATA_W-1:0]         data_i,
  output logic                               push_o,
  input  logic                               full_i,
  output mts_pkg::cmd_t                      cmd_o
);

  // boundary test on the low bits, wrap size is a power of two
  localparam int unsigned WRAP_BITS = $clog2(TAR_WRAP_BYTES);

  logic                          sel_pending_q, sel_pending_d;
  logic [mts_pkg::DATA_W-1:0]    csw_shadow_q, csw_shadow_d;
  logic [mts_pkg::ADDR_W-1:0]    burst_addr_q, burst_addr_d;
  logic                          first_read_q, first_read_d;

  mts_pkg::action_e              action;
  logic [mts_pkg::ADDR_W-1:0]    addr_inc;
  logic                          on_bnd;
  logic [mts_pkg::DATA_W-1:0]    csw_target;
  logic                          csw_used;
  logic                          sel_used;
  logic                          accept;

  assign action      = mts_pkg::action_e'(action_i);
  assign req_ready_o = !full_i;
  assign accept      = req_valid_i && !full_i;
  assign push_o      = accept;
  assign addr_inc    = burst_addr_q + 32'd4;
  assign on_bnd      = (addr_inc[WRAP_BITS-1:0] == '0);

  // classify the request and work out the state that follows
  always_comb begin
    cmd_o        = '0;
    csw_target   = mts_pkg::CSW_BASE | mts_pkg::CSW_SIZE32;
    csw_used     = 1'b0;
    sel_used     = 1'b1;
    burst_addr_d = burst_addr_q;
    first_read_d = first_read_q;
    case (action)
      mts_pkg::ACT_WRITE8: begin
        csw_target = mts_pkg::CSW_BASE | mts_pkg::CSW_SIZE8;
        csw_used   = 1'b1;
        cmd_o.tar  = address_i;
        cmd_o.slots[mts_pkg::SLOT_TARPRE] = 1'b1;
        cmd_o.slots[mts_pkg::SLOT_DRW]    = 1'b1;
        cmd_o.drw_write = 1'b1;
        case (address_i[1:0])
          2'd0:    cmd_o.drw_data = {24'd0, data_i[7:0]};
          2'd1:    cmd_o.drw_data = {16'd0, data_i[7:0], 8'd0};
          2'd2:    cmd_o.drw_data = {8'd0, data_i[7:0], 16'd0};
          default: cmd_o.drw_data = {data_i[7:0], 24'd0};
        endcase
      end
      mts_pkg::ACT_WRITE16: begin
        csw_target = mts_pkg::CSW_BASE | mts_pkg::CSW_SIZE16;
        csw_used   = 1'b1;
        cmd_o.tar  = address_i;
        cmd_o.slots[mts_pkg::SLOT_TARPRE] = 1'b1;
        cmd_o.slots[mts_pkg::SLOT_DRW]    = 1'b1;
        cmd_o.drw_write = 1'b1;
        cmd_o.drw_data  = address_i[1] ? {data_i[15:0], 16'd0} : {16'd0, data_i[15:0]};
      end
      mts_pkg::ACT_WRITE32: begin
        csw_used  = 1'b1;
        cmd_o.tar = address_i;
        cmd_o.slots[mts_pkg::SLOT_TARPRE] = 1'b1;
        cmd_o.slots[mts_pkg::SLOT_DRW]    = 1'b1;
        cmd_o.drw_write = 1'b1;
        cmd_o.drw_data  = data_i;
      end
      mts_pkg::ACT_READ32: begin
        csw_used  = 1'b1;
        cmd_o.tar = address_i;
        cmd_o.slots[mts_pkg::SLOT_TARPRE] = 1'b1;
        cmd_o.slots[mts_pkg::SLOT_DRW]    = 1'b1;
        cmd_o.slots[mts_pkg::SLOT_RDBUF]  = 1'b1;
      end
      mts_pkg::ACT_BURST_START: begin
        csw_target   = mts_pkg::CSW_BASE | mts_pkg::CSW_AUTOINC | mts_pkg::CSW_SIZE32;
        csw_used     = 1'b1;
        burst_addr_d = {address_i[31:2], 2'b00};
        first_read_d = 1'b1;
        cmd_o.tar    = {address_i[31:2], 2'b00};
        cmd_o.slots[mts_pkg::SLOT_TARPRE] = 1'b1;
      end
      mts_pkg::ACT_BURST_WRITE: begin
        burst_addr_d    = addr_inc;
        cmd_o.tar       = addr_inc;
        cmd_o.drw_write = 1'b1;
        cmd_o.drw_data  = data_i;
        cmd_o.slots[mts_pkg::SLOT_DRW]    = 1'b1;
        cmd_o.slots[mts_pkg::SLOT_TARPST] = on_bnd;
      end
      mts_pkg::ACT_BURST_READ: begin
        cmd_o.tar = addr_inc;
        cmd_o.slots[mts_pkg::SLOT_DRW] = 1'b1;
        if (first_read_q) begin
          first_read_d = 1'b0;
        end else begin
          burst_addr_d = addr_inc;
          cmd_o.slots[mts_pkg::SLOT_TARPRE] = on_bnd;
        end
      end
      mts_pkg::ACT_BURST_END: begin
        sel_used     = 1'b0;
        first_read_d = 1'b1;
        cmd_o.slots[mts_pkg::SLOT_RDBUF] = 1'b1;
      end
      default: begin
        sel_used = 1'b0;
      end
    endcase
    cmd_o.slots[mts_pkg::SLOT_SEL] = sel_pending_q && sel_used;
    cmd_o.slots[mts_pkg::SLOT_CSW] = csw_used && (csw_shadow_q != csw_target);
    cmd_o.csw = csw_target;
    csw_shadow_d  = csw_used ? csw_target : csw_shadow_q;
    sel_pending_d = sel_pending_q && !sel_used;
  end

  // shadows and burst tracking advance on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_pending_q <= 1'b1;
      csw_shadow_q  <= mts_pkg::SHADOW_RST;
      burst_addr_q  <= '0;
      first_read_q  <= 1'b1;
    end else if (accept) begin
      sel_pending_q <= sel_pending_d;
      csw_shadow_q  <= csw_shadow_d;
      burst_addr_q  <= burst_addr_d;
      first_read_q  <= first_read_d;
    end
  end

endmodule

// ===== design/mts_queue.sv =====
module mts_queue #(
  parameter int unsigned DEPTH = mts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mts_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output mts_pkg::cmd_t head_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  mts_pkg::cmd_t      entry_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   count_q;

  assign full_o  = (count_q == FULL_CNT);
  assign empty_o = (count_q == '0);
  assign head_o  = entry_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== design/mts_back.sv =====
module mts_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  mts_pkg::cmd_t head_i,
  output logic          pop_o,
  output logic          xact_valid_o,
  input  logic          xact_ready_i,
  output mts_pkg::xact_t xact_o
);

  mts_pkg::cmd_t                  cur_q;
  logic [mts_pkg::NUM_SLOTS-1:0]  mask_q;
  mts_pkg::xact_t                 out_q;
  logic                           out_valid_q;

  logic [mts_pkg::NUM_SLOTS-1:0]  low;
  logic [mts_pkg::NUM_SLOTS-1:0]  rem;
  logic                           fire;
  logic                           load;
  mts_pkg::xact_t                 next_x;

  assign low   = mask_q & (~mask_q + 1'b1);
  assign rem   = mask_q & (mask_q - 1'b1);
  assign fire  = (mask_q != '0) && (!out_valid_q || xact_ready_i);
  assign load  = !empty_i && ((mask_q == '0) || (fire && (rem == '0)));
  assign pop_o = load;

  assign xact_valid_o = out_valid_q;
  assign xact_o       = out_q;

  // build the transaction of the lowest pending slot
  always_comb begin
    next_x      = '0;
    next_x.last = (rem == '0);
    if (low[mts_pkg::SLOT_SEL]) begin
      next_x.is_write = 1'b1;
      next_x.reg_addr = mts_pkg::REG_SELECT;
      next_x.wdata    = mts_pkg::SELECT_VALUE;
    end else if (low[mts_pkg::SLOT_CSW]) begin
      next_x.ap_not_dp = 1'b1;
      next_x.is_write  = 1'b1;
      next_x.reg_addr  = mts_pkg::REG_CSW;
      next_x.wdata     = cur_q.csw;
    end else if (low[mts_pkg::SLOT_TARPRE] || low[mts_pkg::SLOT_TARPST]) begin
      next_x.ap_not_dp = 1'b1;
      next_x.is_write  = 1'b1;
      next_x.reg_addr  = mts_pkg::REG_TAR;
      next_x.wdata     = cur_q.tar;
    end else if (low[mts_pkg::SLOT_DRW]) begin
      next_x.ap_not_dp = 1'b1;
      next_x.is_write  = cur_q.drw_write;
      next_x.reg_addr  = mts_pkg::REG_DRW;
      next_x.wdata     = cur_q.drw_write ? cur_q.drw_data : '0;
    end else begin
      next_x.reg_addr  = mts_pkg::REG_RDBUFF;
    end
  end

  // current request payload and output word
  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= head_i;
    end
    if (fire) begin
      out_q <= next_x;
    end
  end

  // pending slots and output word valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        mask_q <= head_i.slots;
      end else if (fire) begin
        mask_q <= rem;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (xact_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== design/mem_ap_transaction_sequencer.sv =====
// channel   dir  tdata fields (low bit up)    tuser fields (low bit up)   tlast
// s_axis    in   address[31:0] data[63:32]    action[2:0]                 -
// m_axis    out  reg_addr[3:0] wdata[35:4]    ap_not_dp[0] is_write[1]    last of request
//
// each request turns into one to five register words, one word per cycle
// on the master side while m_axis is not stalled; the back end's slot sequencer sets that pace
// the front end takes one request per cycle while the command queue has room
// reset clears the queue, marks select and csw shadows stale, burst address zero
// a stall on m_axis holds the output word and backs up into the queue and s_axis
// TAR_WRAP_BYTES must be a power of two
module mem_ap_transaction_sequencer #(
  parameter int unsigned TAR_WRAP_BYTES = mts_pkg::TAR_WRAP_BYTES_DEF,
  parameter int unsigned QUEUE_DEPTH    = mts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // address, data
  input  logic [mts_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // action
  input  logic [mts_pkg::S_TUSER_W-1:0]   s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // reg_addr, wdata
  output logic [mts_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // ap_not_dp, is_write
  output logic [mts_pkg::M_TUSER_W-1:0]   m_axis_tuser,
  output logic                            m_axis_tlast
);

  logic           push;
  logic           full;
  logic           pop;
  logic           empty;
  mts_pkg::cmd_t  push_cmd;
  mts_pkg::cmd_t  head_cmd;
  mts_pkg::xact_t xact;

  // request classification and shadow state
  mts_front #(
    .TAR_WRAP_BYTES (TAR_WRAP_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .action_i    (s_axis_tuser),
    .address_i   (s_axis_tdata[31:0]),
    .data_i      (s_axis_tdata[63:32]),
    .push_o      (push),
    .full_i      (full),
    .cmd_o       (push_cmd)
  );

  // command queue
  mts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head_cmd)
  );

  // transaction issue
  mts_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .head_i       (head_cmd),
    .pop_o        (pop),
    .xact_valid_o (m_axis_tvalid),
    .xact_ready_i (m_axis_tready),
    .xact_o       (xact)
  );

  assign m_axis_tdata = {4'b0000, xact.wdata, xact.reg_addr};
  assign m_axis_tuser = {xact.is_write, xact.ap_not_dp};
  assign m_axis_tlast = xact.last;

endmodule
